// ===== src/single_tube_clock_set_and_display_macros.svh =====
// Assertion helpers for the single-tube clock block.
`ifndef SINGLE_TUBE_CLOCK_SET_AND_DISPLAY_MACROS_SVH
`define SINGLE_TUBE_CLOCK_SET_AND_DISPLAY_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define STC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition at one edge implies another at the next edge.
`define STC_ASSERT_NEXT(label, cond, nxt, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (nxt)) \
    else $error(msg);

`endif

// ===== src/stc_pkg.sv =====
package stc_pkg;

  typedef logic [1:0] button_t;
  localparam button_t BtnNone  = 2'd0;
  localparam button_t BtnShort = 2'd1;
  localparam button_t BtnLong  = 2'd2;

  typedef logic [2:0] step_t;
  localparam step_t StepIdle       = 3'd0;
  localparam step_t StepHourTens   = 3'd1;
  localparam step_t StepHourUnits  = 3'd2;
  localparam step_t StepMinTens    = 3'd3;
  localparam step_t StepMinUnits   = 3'd4;
  localparam step_t StepNightOff   = 3'd5;
  localparam step_t StepDone       = 3'd6;

  localparam logic [3:0] BlankCode  = 4'd10;
  localparam logic [3:0] PhaseHourT = 4'd1;
  localparam logic [3:0] PhaseHourU = 4'd3;
  localparam logic [3:0] PhaseMinT  = 4'd5;
  localparam logic [3:0] PhaseMinU  = 4'd7;
  localparam logic [3:0] PhaseEnd   = 4'd8;

  localparam logic [4:0] NightStartHour = 5'd23;
  localparam logic [4:0] NightEndHour   = 5'd6;
  localparam logic [4:0] DayFirstHour   = 5'd5;

  localparam logic [4:0] WrapHourTens  = 5'd3;
  localparam logic [4:0] WrapUnits     = 5'd10;
  localparam logic [4:0] WrapMinTens   = 5'd6;
  localparam logic [4:0] WrapNightOff  = 5'd2;

  // Tens digit of a value up to 63.
  function automatic logic [2:0] div10(input logic [5:0] v);
    logic [2:0] q;
    if (v >= 6'd60) q = 3'd6;
    else if (v >= 6'd50) q = 3'd5;
    else if (v >= 6'd40) q = 3'd4;
    else if (v >= 6'd30) q = 3'd3;
    else if (v >= 6'd20) q = 3'd2;
    else if (v >= 6'd10) q = 3'd1;
    else q = 3'd0;
    return q;
  endfunction

  // Units digit of a value up to 63.
  function automatic logic [3:0] mod10(input logic [5:0] v);
    logic [6:0] tens10;
    logic [6:0] diff;
    tens10 = 7'(div10(v)) * 7'd10;
    diff   = {1'b0, v} - tens10;
    return diff[3:0];
  endfunction

  // Increment and wrap to zero at the limit.
  function automatic logic [4:0] wrap_inc(input logic [4:0] v, input logic [4:0] limit);
    logic [5:0] nxt;
    nxt = {1'b0, v} + 6'd1;
    return (nxt >= {1'b0, limit}) ? 5'd0 : nxt[4:0];
  endfunction

endpackage

// ===== src/single_tube_clock_set_and_display.sv =====
// Single-tube clock controller: each input word is one pass of the clock's main
// loop (show tick, digit tick, button result, live time) and yields exactly one
// result word (tube drive, clock load strobe and values, digit timer restart).
// A long press opens the five-step setting menu (hour tens, hour units, minute
// tens, minute units, night-off flag); short presses wrap-increment the blinking
// item and a long press on the last step loads the clock. A show tick flashes
// the four time digits with blanks between them; with night-off set the tube
// stays dark at night and a short press flashes the time once.
// Timing: one word per clock cycle, sustained while results are taken. The
// state update and the result are computed in one combinational pass from
// the state registers and the input port, and land in the output register
// at the accepting edge. Input is taken whenever the output register is empty
// or being drained in the same cycle, so a result shows up the cycle after acceptance.
module single_tube_clock_set_and_display (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   show_tick_i,
  input  logic                   digit_tick_i,
  input  stc_pkg::button_t       button_i,
  input  logic [4:0]             now_hour_i,
  input  logic [5:0]             now_minute_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   tube_update_o,
  output logic [3:0]             shown_digit_o,
  output logic                   cathode_lit_o,
  output logic                   set_strobe_o,
  output logic [4:0]             set_hour_o,
  output logic [5:0]             set_minute_o,
  output logic                   restart_digit_timer_o
);
  import stc_pkg::*;

  // Controller state.
  step_t      menu_step_q, menu_step_d;
  logic       in_menu_q, in_menu_d;
  logic [1:0] hour_tens_q, hour_tens_d;
  logic [3:0] hour_units_q, hour_units_d;
  logic [2:0] minute_tens_q, minute_tens_d;
  logic [3:0] minute_units_q, minute_units_d;
  logic       night_off_q, night_off_d;
  logic [3:0] flash_phase_q, flash_phase_d;
  logic       blink_on_q, blink_on_d;
  logic       showing_time_q, showing_time_d;
  logic       capture_pending_q, capture_pending_d;
  logic       spot_showing_q, spot_showing_d;
  logic [4:0] captured_hour_q, captured_hour_d;

  // Result word register.
  logic       out_valid_q;
  logic       tube_update_q, tube_update_d;
  logic [3:0] shown_digit_q, shown_digit_d;
  logic       cathode_lit_q, cathode_lit_d;
  logic       set_strobe_q, set_strobe_d;
  logic [4:0] set_hour_q, set_hour_d;
  logic [5:0] set_minute_q, set_minute_d;
  logic       restart_q, restart_d;

  logic accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // One pass of the main loop: show tick, then button, then tube.
  always_comb begin
    logic       tick;
    logic       flash;
    logic       drive;
    logic [3:0] digit;
    logic [6:0] hour_sum;
    logic [6:0] min_sum;
    logic [2:0] tens_full;
    logic [4:0] bumped;

    menu_step_d       = menu_step_q;
    in_menu_d         = in_menu_q;
    hour_tens_d       = hour_tens_q;
    hour_units_d      = hour_units_q;
    minute_tens_d     = minute_tens_q;
    minute_units_d    = minute_units_q;
    night_off_d       = night_off_q;
    flash_phase_d     = flash_phase_q;
    blink_on_d        = blink_on_q;
    showing_time_d    = showing_time_q;
    capture_pending_d = capture_pending_q;
    spot_showing_d    = spot_showing_q;
    captured_hour_d   = captured_hour_q;

    tube_update_d = 1'b0;
    shown_digit_d = 4'd0;
    cathode_lit_d = 1'b0;
    set_strobe_d  = 1'b0;
    set_hour_d    = 5'd0;
    set_minute_d  = 6'd0;
    restart_d     = 1'b0;

    tick      = digit_tick_i;
    flash     = 1'b0;
    drive     = 1'b0;
    digit     = BlankCode;
    hour_sum  = 7'd0;
    min_sum   = 7'd0;
    tens_full = 3'd0;
    bumped    = 5'd0;

    // Show tick: start a time display unless the night flash runs.
    if (show_tick_i && !spot_showing_q) begin
      showing_time_d    = 1'b1;
      blink_on_d        = 1'b1;
      capture_pending_d = 1'b1;
      flash_phase_d     = 4'd0;
    end

    // Button handling.
    if (!in_menu_q && button_i == BtnShort && night_off_q
        && (now_hour_i >= NightStartHour || now_hour_i <= NightEndHour)) begin
      spot_showing_d    = 1'b1;
      night_off_d       = 1'b0;
      capture_pending_d = 1'b1;
      flash_phase_d     = 4'd0;
      blink_on_d        = 1'b1;
    end else if (!in_menu_q && button_i == BtnLong) begin
      in_menu_d       = 1'b1;
      menu_step_d     = StepHourTens;
      captured_hour_d = now_hour_i;
      tens_full       = div10({1'b0, now_hour_i});
      hour_tens_d     = tens_full[1:0];
      hour_units_d    = mod10({1'b0, now_hour_i});
      minute_tens_d   = div10(now_minute_i);
      minute_units_d  = mod10(now_minute_i);
      night_off_d     = 1'b0;
    end else if (in_menu_q && button_i == BtnShort) begin
      case (menu_step_q)
        StepHourTens: begin
          bumped      = wrap_inc({3'd0, hour_tens_q}, WrapHourTens);
          hour_tens_d = bumped[1:0];
        end
        StepHourUnits: begin
          bumped       = wrap_inc({1'b0, hour_units_q}, WrapUnits);
          hour_units_d = bumped[3:0];
        end
        StepMinTens: begin
          bumped        = wrap_inc({2'd0, minute_tens_q}, WrapMinTens);
          minute_tens_d = bumped[2:0];
        end
        StepMinUnits: begin
          bumped         = wrap_inc({1'b0, minute_units_q}, WrapUnits);
          minute_units_d = bumped[3:0];
        end
        StepNightOff: begin
          bumped      = wrap_inc({4'd0, night_off_q}, WrapNightOff);
          night_off_d = bumped[0];
        end
        default: ;
      endcase
    end else if (in_menu_q && button_i == BtnLong) begin
      menu_step_d = menu_step_q + 3'd1;
      if (menu_step_d == StepDone) begin
        // Leave the menu and load the clock.
        in_menu_d    = 1'b0;
        menu_step_d  = StepIdle;
        hour_sum     = 7'(hour_tens_q) * 7'd10 + 7'(hour_units_q);
        min_sum      = 7'(minute_tens_q) * 7'd10 + 7'(minute_units_q);
        set_strobe_d = 1'b1;
        set_hour_d   = hour_sum[4:0];
        set_minute_d = min_sum[5:0];
        restart_d    = 1'b1;
        blink_on_d   = 1'b1;
        tick         = 1'b0;
      end
    end

    // Tube.
    if (menu_step_d != StepIdle) begin
      if (tick) begin
        if (blink_on_d) begin
          drive = 1'b1;
          case (menu_step_d)
            StepHourTens:  digit = {2'd0, hour_tens_d};
            StepHourUnits: digit = hour_units_d;
            StepMinTens:   digit = {1'b0, minute_tens_d};
            StepMinUnits:  digit = minute_units_d;
            StepNightOff:  digit = {3'd0, night_off_d};
            default:       drive = 1'b0;
          endcase
        end else begin
          drive = 1'b1;
        end
        blink_on_d = !blink_on_d;
      end
    end else if (spot_showing_d || showing_time_d) begin
      flash = 1'b1;
      if (capture_pending_d) begin
        captured_hour_d   = now_hour_i;
        tens_full         = div10({1'b0, now_hour_i});
        hour_tens_d       = tens_full[1:0];
        hour_units_d      = mod10({1'b0, now_hour_i});
        minute_tens_d     = div10(now_minute_i);
        minute_units_d    = mod10(now_minute_i);
        capture_pending_d = 1'b0;
      end
      if (tick) begin
        flash_phase_d = flash_phase_d + 4'd1;
        if (blink_on_d) begin
          drive = 1'b1;
          case (flash_phase_d)
            PhaseHourT: digit = {2'd0, hour_tens_d};
            PhaseHourU: digit = hour_units_d;
            PhaseMinT:  digit = {1'b0, minute_tens_d};
            PhaseMinU:  digit = minute_units_d;
            default:    drive = 1'b0;
          endcase
        end else begin
          drive = 1'b1;
        end
        blink_on_d = !blink_on_d;
      end
    end

    if (drive) begin
      tube_update_d = 1'b1;
      shown_digit_d = digit;
      cathode_lit_d = (digit != BlankCode) && (!night_off_d
                      || (captured_hour_d < NightStartHour && captured_hour_d > DayFirstHour)
                      || menu_step_d != StepIdle);
    end

    // End of a flash sequence; the night flash re-arms night-off.
    if (flash && tick && flash_phase_d == PhaseEnd) begin
      if (spot_showing_d) begin
        spot_showing_d = 1'b0;
        night_off_d    = 1'b1;
      end else begin
        showing_time_d = 1'b0;
      end
    end
  end

  // Hold state; advance on an accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      menu_step_q       <= StepIdle;
      in_menu_q         <= 1'b0;
      hour_tens_q       <= 2'd0;
      hour_units_q      <= 4'd0;
      minute_tens_q     <= 3'd0;
      minute_units_q    <= 4'd0;
      night_off_q       <= 1'b0;
      flash_phase_q     <= 4'd0;
      blink_on_q        <= 1'b1;
      showing_time_q    <= 1'b0;
      capture_pending_q <= 1'b1;
      spot_showing_q    <= 1'b0;
      captured_hour_q   <= 5'd0;
    end else if (accept) begin
      menu_step_q       <= menu_step_d;
      in_menu_q         <= in_menu_d;
      hour_tens_q       <= hour_tens_d;
      hour_units_q      <= hour_units_d;
      minute_tens_q     <= minute_tens_d;
      minute_units_q    <= minute_units_d;
      night_off_q       <= night_off_d;
      flash_phase_q     <= flash_phase_d;
      blink_on_q        <= blink_on_d;
      showing_time_q    <= showing_time_d;
      capture_pending_q <= capture_pending_d;
      spot_showing_q    <= spot_showing_d;
      captured_hour_q   <= captured_hour_d;
    end
  end

  // Output word valid: set on accept, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output word payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      tube_update_q <= tube_update_d;
      shown_digit_q <= shown_digit_d;
      cathode_lit_q <= cathode_lit_d;
      set_strobe_q  <= set_strobe_d;
      set_hour_q    <= set_hour_d;
      set_minute_q  <= set_minute_d;
      restart_q     <= restart_d;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign tube_update_o         = tube_update_q;
  assign shown_digit_o         = shown_digit_q;
  assign cathode_lit_o         = cathode_lit_q;
  assign set_strobe_o          = set_strobe_q;
  assign set_hour_o            = set_hour_q;
  assign set_minute_o          = set_minute_q;
  assign restart_digit_timer_o = restart_q;

`include "single_tube_clock_set_and_display_macros.svh"

  `STC_ASSERT(a_menu_flag_matches_step, in_menu_q == (menu_step_q != StepIdle),
              "menu flag and step disagree")
  `STC_ASSERT(a_lit_needs_digit,
              !(out_valid_q && cathode_lit_q) || (tube_update_q && shown_digit_q != BlankCode),
              "cathode lit without a digit")
  `STC_ASSERT(a_strobe_leaves_menu,
              !(out_valid_q && set_strobe_q) || (restart_q && !in_menu_q),
              "load strobe while menu still open")
  `STC_ASSERT_NEXT(a_accept_fills_output, accept, out_valid_q,
                   "accepted word produced no result")

endmodule

// ===== tb/sv/tb_single_tube_clock_set_and_display.sv =====
`timescale 1ns / 1ps

module tb_single_tube_clock_set_and_display;
  import stc_pkg::*;

  // Button code that the block must treat like no press.
  localparam button_t BtnIgnored = 2'd3;

  // Random words to generate after the directed opening.
  localparam int RandomWords = 850;

  // One input word, plus a flag that makes the driver hold it back until
  // every outstanding result has drained.
  typedef struct packed {
    logic       drain_first;
    logic       show_tick;
    logic       digit_tick;
    button_t    button;
    logic [4:0] hour;
    logic [5:0] minute;
  } word_t;

  // One result word, in port order.
  typedef struct packed {
    logic       tube_update;
    logic [3:0] shown_digit;
    logic       cathode_lit;
    logic       set_strobe;
    logic [4:0] set_hour;
    logic [5:0] set_minute;
    logic       restart_timer;
  } result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic  in_valid  = 1'b0;
  logic  out_ready = 1'b0;
  word_t cur_word  = '0;

  logic       in_ready_o;
  logic       out_valid_o;
  logic       tube_update_o;
  logic [3:0] shown_digit_o;
  logic       cathode_lit_o;
  logic       set_strobe_o;
  logic [4:0] set_hour_o;
  logic [5:0] set_minute_o;
  logic       restart_digit_timer_o;

  word_t   pending_words[$];
  result_t expected_results[$];

  int total_words = 0;
  int sent_words  = 0;
  int fault_count = 0;
  bit drain_next  = 1'b0;

  // Shadow copy of the controller state.
  step_t      step_q      = StepIdle;
  logic       in_menu_q   = 1'b0;
  logic [1:0] hr_tens     = '0;
  logic [3:0] hr_units    = '0;
  logic [2:0] mn_tens     = '0;
  logic [3:0] mn_units    = '0;
  logic       night_off_q = 1'b0;
  logic [3:0] phase_q     = '0;
  logic       blink_q     = 1'b1;
  logic       show_active = 1'b0;
  logic       capture_due = 1'b1;
  logic       spot_active = 1'b0;
  logic [4:0] cap_hour    = '0;

  single_tube_clock_set_and_display u_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid),
    .in_ready_o            (in_ready_o),
    .show_tick_i           (cur_word.show_tick),
    .digit_tick_i          (cur_word.digit_tick),
    .button_i              (cur_word.button),
    .now_hour_i            (cur_word.hour),
    .now_minute_i          (cur_word.minute),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready),
    .tube_update_o         (tube_update_o),
    .shown_digit_o         (shown_digit_o),
    .cathode_lit_o         (cathode_lit_o),
    .set_strobe_o          (set_strobe_o),
    .set_hour_o            (set_hour_o),
    .set_minute_o          (set_minute_o),
    .restart_digit_timer_o (restart_digit_timer_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow model
  // ---------------------------------------------------------------------------

  // Advance a menu digit and fall back to zero at or above its limit; this also
  // clears digits that came in out of range from the running clock.
  function automatic int wrap_bump(input int v, input int limit);
    return (v + 1 >= limit) ? 0 : v + 1;
  endfunction

  // Select a cathode. Blank is never lit; otherwise the night rule darkens the
  // tube unless night-off is clear, the captured hour is daytime, or the menu
  // is open.
  function automatic result_t select_digit(input result_t r, input logic [3:0] d);
    result_t o;
    o = r;
    o.tube_update = 1'b1;
    o.shown_digit = d;
    o.cathode_lit = (d != BlankCode) &&
                    (!night_off_q || (cap_hour < NightStartHour && cap_hour > DayFirstHour) ||
                     step_q != StepIdle);
    return o;
  endfunction

  // Latch the live time as the captured hour and the four digits.
  task automatic grab_time(input logic [4:0] hr, input logic [5:0] mn);
    cap_hour = hr;
    hr_tens  = 2'(hr / 10);
    hr_units = 4'(hr % 10);
    mn_tens  = 3'(mn / 10);
    mn_units = 4'(mn % 10);
  endtask

  // Run one pass of the main loop on an accepted word and queue its result.
  task automatic predict_pass(input word_t w);
    result_t r;
    logic    tick;
    logic    spot;
    r    = '0;
    tick = w.digit_tick;

    // Show tick first; the night flash ignores it.
    if (w.show_tick && !spot_active) begin
      show_active = 1'b1;
      blink_q     = 1'b1;
      capture_due = 1'b1;
      phase_q     = '0;
    end

    // Then the button.
    if (!in_menu_q && w.button == BtnShort && night_off_q &&
        (w.hour >= NightStartHour || w.hour <= NightEndHour)) begin
      spot_active = 1'b1;
      night_off_q = 1'b0;
      capture_due = 1'b1;
      phase_q     = '0;
      blink_q     = 1'b1;
    end else if (!in_menu_q && w.button == BtnLong) begin
      in_menu_q   = 1'b1;
      step_q      = StepHourTens;
      grab_time(w.hour, w.minute);
      night_off_q = 1'b0;
    end else if (in_menu_q && w.button == BtnShort) begin
      case (step_q)
        StepHourTens:  hr_tens     = 2'(wrap_bump(int'(hr_tens), int'(WrapHourTens)));
        StepHourUnits: hr_units    = 4'(wrap_bump(int'(hr_units), int'(WrapUnits)));
        StepMinTens:   mn_tens     = 3'(wrap_bump(int'(mn_tens), int'(WrapMinTens)));
        StepMinUnits:  mn_units    = 4'(wrap_bump(int'(mn_units), int'(WrapUnits)));
        StepNightOff:  night_off_q = 1'(wrap_bump(int'(night_off_q), int'(WrapNightOff)));
        default: ;
      endcase
    end else if (in_menu_q && w.button == BtnLong) begin
      step_q = step_q + 3'd1;
      if (step_q == StepDone) begin
        // Load the clock; truncate to the port widths and drop this tick.
        in_menu_q       = 1'b0;
        step_q          = StepIdle;
        r.set_strobe    = 1'b1;
        r.set_hour      = 5'(int'(hr_tens) * 10 + int'(hr_units));
        r.set_minute    = 6'(int'(mn_tens) * 10 + int'(mn_units));
        r.restart_timer = 1'b1;
        blink_q         = 1'b1;
        tick            = 1'b0;
      end
    end

    // Then the tube.
    if (step_q != StepIdle) begin
      if (tick) begin
        if (blink_q) begin
          case (step_q)
            StepHourTens:  r = select_digit(r, 4'(hr_tens));
            StepHourUnits: r = select_digit(r, hr_units);
            StepMinTens:   r = select_digit(r, 4'(mn_tens));
            StepMinUnits:  r = select_digit(r, mn_units);
            StepNightOff:  r = select_digit(r, 4'(night_off_q));
            default: ;
          endcase
        end else begin
          r = select_digit(r, BlankCode);
        end
        blink_q = ~blink_q;
      end
    end else if (spot_active || show_active) begin
      spot = spot_active;
      if (capture_due) begin
        grab_time(w.hour, w.minute);
        capture_due = 1'b0;
      end
      if (tick) begin
        // The phase wraps at sixteen; only a return to the end phase stops it.
        phase_q = phase_q + 4'd1;
        if (blink_q) begin
          case (phase_q)
            PhaseHourT: r = select_digit(r, 4'(hr_tens));
            PhaseHourU: r = select_digit(r, hr_units);
            PhaseMinT:  r = select_digit(r, 4'(mn_tens));
            PhaseMinU:  r = select_digit(r, mn_units);
            default: ;
          endcase
        end else begin
          r = select_digit(r, BlankCode);
        end
        blink_q = ~blink_q;
        if (phase_q == PhaseEnd) begin
          if (spot) begin
            spot_active = 1'b0;
            night_off_q = 1'b1;
          end else begin
            show_active = 1'b0;
          end
        end
      end
    end

    expected_results.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  task automatic add_word(input logic s, input logic t, input button_t b,
                          input int h, input int m);
    word_t w;
    w.drain_first = drain_next;
    w.show_tick   = s;
    w.digit_tick  = t;
    w.button      = b;
    w.hour        = 5'(h);
    w.minute      = 6'(m);
    drain_next    = 1'b0;
    pending_words.push_back(w);
  endtask

  // Mostly legal time, now and then the out-of-range codes the ports allow.
  function automatic int pick_hour();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(24, 31) : $urandom_range(0, 23);
  endfunction

  function automatic int pick_minute();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(60, 63) : $urandom_range(0, 59);
  endfunction

  function automatic button_t idle_button();
    return ($urandom_range(0, 19) == 0) ? BtnIgnored : BtnNone;
  endfunction

  // Walk the whole menu: a long press to open, a few short presses and ticks
  // per step, a long press to advance. A non-negative night_presses fixes the
  // number of short presses on the night-off step.
  task automatic gen_menu_run(input int night_presses);
    int n;
    add_word($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)), BtnLong, pick_hour(),
             pick_minute());
    for (int s = 1; s <= 5; s++) begin
      n = (s == 5 && night_presses >= 0) ? night_presses : $urandom_range(0, 4);
      repeat (n)
        add_word(1'b0, 1'($urandom_range(0, 1)), BtnShort, pick_hour(), pick_minute());
      repeat ($urandom_range(0, 3))
        add_word($urandom_range(0, 7) == 0, $urandom_range(0, 3) != 0, idle_button(),
                 pick_hour(), pick_minute());
      add_word($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)), BtnLong, pick_hour(),
               pick_minute());
    end
  endtask

  // A show tick and the ticks that flash the time, with an odd press mixed in.
  task automatic gen_show_run();
    button_t b;
    add_word(1'b1, 1'($urandom_range(0, 1)), idle_button(), pick_hour(), pick_minute());
    repeat ($urandom_range(6, 11)) begin
      b = ($urandom_range(0, 19) == 0) ? BtnShort : idle_button();
      add_word($urandom_range(0, 19) == 0, $urandom_range(0, 4) != 0, b, pick_hour(),
               pick_minute());
    end
  endtask

  // Arm night-off through the menu, then ask for the one-shot night flash.
  task automatic gen_night_run();
    int h;
    gen_menu_run(2 * $urandom_range(0, 2) + 1);
    h = $urandom_range(0, 1) ? $urandom_range(23, 31) : $urandom_range(0, 6);
    add_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), BtnShort, h,
             pick_minute());
    repeat ($urandom_range(7, 10))
      add_word($urandom_range(0, 5) == 0, $urandom_range(0, 4) != 0, idle_button(), h,
               pick_minute());
  endtask

  task automatic gen_noise();
    repeat ($urandom_range(1, 6))
      add_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               button_t'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom_range(0, 63));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present the next word once the current one is taken, and feed
  // every accepted word to the shadow model.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    word_t nxt;
    int    idle_pct;
    if (!rst_ni) begin
      in_valid    <= 1'b0;
      step_q      = StepIdle;
      in_menu_q   = 1'b0;
      hr_tens     = '0;
      hr_units    = '0;
      mn_tens     = '0;
      mn_units    = '0;
      night_off_q = 1'b0;
      phase_q     = '0;
      blink_q     = 1'b1;
      show_active = 1'b0;
      capture_due = 1'b1;
      spot_active = 1'b0;
      cap_hour    = '0;
    end else begin
      if (in_valid && in_ready_o) predict_pass(cur_word);
      // Sender idles rarely first, then often, then never.
      idle_pct = (sent_words < total_words / 3) ? 7 :
                 (sent_words < 2 * total_words / 3) ? 76 : 0;
      if (!in_valid || in_ready_o) begin
        // Hold a drain-first word until nothing is outstanding.
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct &&
            !(pending_words[0].drain_first && expected_results.size() != 0)) begin
          nxt = pending_words.pop_front();
          cur_word   <= nxt;
          in_valid   <= 1'b1;
          sent_words += 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each accepted result against the oldest expectation and
  // stall the result channel at random.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : watch_proc
    result_t got;
    result_t want;
    int      stall_pct;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        got.tube_update   = tube_update_o;
        got.shown_digit   = shown_digit_o;
        got.cathode_lit   = cathode_lit_o;
        got.set_strobe    = set_strobe_o;
        got.set_hour      = set_hour_o;
        got.set_minute    = set_minute_o;
        got.restart_timer = restart_digit_timer_o;
        if (expected_results.size() == 0) begin
          fault_count += 1;
          if (fault_count <= 10)
            $display({"unexpected result word: upd %0d digit %0d lit %0d strobe %0d",
                      " hr %0d mn %0d rst %0d"},
                     got.tube_update, got.shown_digit, got.cathode_lit, got.set_strobe,
                     got.set_hour, got.set_minute, got.restart_timer);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fault_count += 1;
            if (fault_count <= 10) begin
              $display("mismatch at %0t: upd %0d/%0d digit %0d/%0d lit %0d/%0d strobe %0d/%0d",
                       $realtime, want.tube_update, got.tube_update, want.shown_digit,
                       got.shown_digit, want.cathode_lit, got.cathode_lit, want.set_strobe,
                       got.set_strobe);
              $display("  (expected/actual) hr %0d/%0d mn %0d/%0d restart %0d/%0d",
                       want.set_hour, got.set_hour, want.set_minute, got.set_minute,
                       want.restart_timer, got.restart_timer);
            end
          end
        end
      end
      // Receiver stalls often first, then rarely, then never.
      stall_pct = (sent_words < total_words / 3) ? 76 :
                  (sent_words < 2 * total_words / 3) ? 7 : 0;
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int pick;

    // Directed opening: idle pass and a short time display.
    add_word(1'b0, 1'b0, BtnNone, 0, 0);
    add_word(1'b1, 1'b1, BtnNone, 23, 59);
    add_word(1'b0, 1'b1, BtnNone, 0, 0);
    add_word(1'b0, 1'b1, BtnNone, 0, 0);
    // Ignored button code together with a fresh show tick.
    add_word(1'b1, 1'b0, BtnIgnored, 12, 34);
    // Menu from an out-of-range time; the bumped hour and minute overflow their
    // widths, night-off gets armed, and the closing tick must be dropped.
    add_word(1'b0, 1'b0, BtnLong, 31, 63);
    add_word(1'b0, 1'b1, BtnNone, 0, 0);
    add_word(1'b0, 1'b0, BtnLong, 0, 0);
    add_word(1'b0, 1'b0, BtnShort, 0, 0);
    add_word(1'b0, 1'b0, BtnLong, 0, 0);
    add_word(1'b0, 1'b0, BtnLong, 0, 0);
    add_word(1'b0, 1'b0, BtnShort, 0, 0);
    add_word(1'b0, 1'b0, BtnLong, 0, 0);
    add_word(1'b0, 1'b0, BtnShort, 0, 0);
    add_word(1'b0, 1'b1, BtnLong, 0, 0);
    // Night flash, with a show tick that it must ignore, run to its end.
    add_word(1'b0, 1'b1, BtnShort, 23, 5);
    add_word(1'b1, 1'b1, BtnNone, 23, 5);
    repeat (6) add_word(1'b0, 1'b1, BtnNone, 23, 5);
    // Night-off now set again: the display stays dark at night.
    add_word(1'b1, 1'b1, BtnNone, 2, 0);

    // Random part, draining the pipe at its start and again later on.
    drain_next = 1'b1;
    while (pending_words.size() < 24 + RandomWords) begin
      if (pending_words.size() >= 24 + 2 * RandomWords / 3 &&
          pending_words.size() < 24 + 2 * RandomWords / 3 + 20)
        drain_next = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 35) gen_menu_run(-1);
      else if (pick < 65) gen_show_run();
      else if (pick < 80) gen_night_run();
      else gen_noise();
    end
    total_words = pending_words.size();

    // Hold reset, then release it on a clock edge.
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the last word to go in and its result to come out.
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    if (fault_count == 0 && expected_results.size() == 0) begin
      $display("tb_single_tube_clock_set_and_display: done, clean");
    end else begin
      $display("tb_single_tube_clock_set_and_display: done, errors");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #5_000_000;
    $display("tb_single_tube_clock_set_and_display: done, errors");
    $finish;
  end

endmodule
